// ===== rtl/fr2p_pkg.sv =====
// shared types, constants and mask analysis for the float rgb pixel packer
`default_nettype none
package fr2p_pkg;

  localparam int unsigned ChanCount = 3;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned MaxWidth = 16;
  localparam int unsigned ShiftWidth = 5;
  localparam int unsigned PixelWidth = 24;
  localparam int unsigned ProdWidth = 40;
  localparam int unsigned RoundWidth = 41;
  localparam int unsigned IndexWidth = 2;

  localparam logic [IndexWidth-1:0] RegPixelMode = 2'd0;
  localparam logic [IndexWidth-1:0] RegRedMask   = 2'd1;
  localparam logic [IndexWidth-1:0] RegGreenMask = 2'd2;
  localparam logic [IndexWidth-1:0] RegBlueMask  = 2'd3;

  localparam logic [MaxWidth-1:0] RedMaskReset   = 16'hF800;
  localparam logic [MaxWidth-1:0] GreenMaskReset = 16'h07E0;
  localparam logic [MaxWidth-1:0] BlueMaskReset  = 16'h001F;
  localparam logic [MaxWidth-1:0] ByteMax        = 16'd255;

  typedef struct packed {
    logic [ShiftWidth-1:0] shift;
    logic [MaxWidth-1:0]   maxv;
  } chan_fmt_t;

  // lowest set bit gives the shift, the run of ones above it the maximum
  function automatic chan_fmt_t analyse_mask(input logic [MaxWidth-1:0] m);
    chan_fmt_t f;
    logic [MaxWidth-1:0] ms;
    logic [MaxWidth:0] inc;
    f.shift = '0;
    for (int i = MaxWidth - 1; i >= 0; i--) begin
      if (m[i]) f.shift = ShiftWidth'(i);
    end
    ms = m >> f.shift;
    inc = {1'b0, ms} + 17'd1;
    f.maxv = ms & ~inc[MaxWidth-1:0];
    return f;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fr2p_lane.sv =====
// one channel lane: float times maximum, single rounding, truncation and clamp
`default_nettype none
module fr2p_lane (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [fr2p_pkg::ValueWidth-1:0] value,
  input  wire logic [fr2p_pkg::MaxWidth-1:0]   maxv,
  output logic                               out_valid,
  output logic [fr2p_pkg::MaxWidth-1:0]        chan
);
  import fr2p_pkg::*;

  // stage 1: decode and product
  logic                  v1, kill1, sat1;
  logic [7:0]            rsh1;
  logic [MaxWidth-1:0]   max1;
  logic [ProdWidth-1:0]  prod1;
  logic [7:0]            expf;
  logic [22:0]           frac;
  logic [23:0]           mant;

  assign expf = value[30:23];
  assign frac = value[22:0];
  assign mant = (expf == 8'd0) ? {1'b0, frac} : {1'b1, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    kill1 <= value[31] || (expf == 8'hFF && frac != 23'd0);
    sat1  <= expf >= 8'd127;
    rsh1  <= (expf == 8'd0) ? 8'd149 : 8'd150 - expf;
    max1  <= maxv;
    prod1 <= ProdWidth'(mant) * ProdWidth'(maxv);
  end

  // stage 2: round the product to 24 significant bits, ties to even
  logic                   v2, kill2, sat2;
  logic [7:0]             rsh2;
  logic [MaxWidth-1:0]    max2;
  logic [RoundWidth-1:0]  rnd2;
  logic [5:0]             hb;
  logic [4:0]             d;
  logic [ProdWidth-1:0]   dmask, kept, stick;
  logic                   lsb, halfb, up;
  logic [RoundWidth-1:0]  rnd_next;

  always_comb begin
    hb = '0;
    for (int i = 0; i < ProdWidth; i++) begin
      if (prod1[i]) hb = 6'(i);
    end
    d = (hb >= 6'd24) ? 5'(hb - 6'd23) : 5'd0;
    dmask = (ProdWidth'(1) << d) - ProdWidth'(1);
    kept  = prod1 & ~dmask;
    stick = prod1 & (dmask >> 1);
    lsb   = prod1[d];
    halfb = (d != 5'd0) && prod1[d - 5'd1];
    up    = halfb && ((stick != '0) || lsb);
    rnd_next = {1'b0, kept} + (up ? (RoundWidth'(1) << d) : RoundWidth'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    kill2 <= kill1;
    sat2  <= sat1;
    rsh2  <= rsh1;
    max2  <= max1;
    rnd2  <= rnd_next;
  end

  // stage 3: scale down, truncate toward zero, clamp
  logic [RoundWidth-1:0] shifted;
  logic [MaxWidth-1:0]   chan_next;

  always_comb begin
    shifted = (rsh2 >= 8'(RoundWidth)) ? '0 : (rnd2 >> rsh2);
    if (kill2) begin
      chan_next = '0;
    end else if (sat2 || shifted > RoundWidth'(max2)) begin
      chan_next = max2;
    end else begin
      chan_next = shifted[MaxWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
    chan <= chan_next;
  end

endmodule
`default_nettype wire

// ===== rtl/fr2p_merge.sv =====
// merge stage: packs the three lane results into one pixel word
`default_nettype none
module fr2p_merge (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         pixel_mode,
  input  wire logic [fr2p_pkg::MaxWidth-1:0]  chan [fr2p_pkg::ChanCount],
  input  wire fr2p_pkg::chan_fmt_t          fmt  [fr2p_pkg::ChanCount],
  output logic                              done,
  output logic [fr2p_pkg::PixelWidth-1:0]     packed_pixel
);
  import fr2p_pkg::*;

  logic [MaxWidth-1:0]   px16;
  logic [PixelWidth-1:0] pixel_next;

  always_comb begin
    px16 = '0;
    for (int i = 0; i < ChanCount; i++) begin
      px16 = px16 | (chan[i] << fmt[i].shift[3:0]);
    end
    if (pixel_mode) begin
      pixel_next = {chan[0][7:0], chan[1][7:0], chan[2][7:0]};
    end else begin
      pixel_next = {8'd0, px16};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
    packed_pixel <= pixel_next;
  end

endmodule
`default_nettype wire

// ===== rtl/float_rgb_to_packed_pixel_core.sv =====
// top level: float rgb to packed 16-bit or byte-packed display pixel
// path: a word accepted on start passes the lane stages and the merge stage, then appears on packed_pixel with done
// throughput: one word per clock, busy is always low; set by the three lane pipelines
// each lane is three stages (product, rounding, scaling) and the merge stage adds one
// reset: synchronous, clears the pipeline valids, mode 16-bit and masks to 5-6-5
// results cannot be held off, every result shows for exactly one cycle
`default_nettype none
module float_rgb_to_packed_pixel_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [fr2p_pkg::ValueWidth-1:0]   red_value,
  input  wire logic [fr2p_pkg::ValueWidth-1:0]   green_value,
  input  wire logic [fr2p_pkg::ValueWidth-1:0]   blue_value,
  input  wire logic                            wr_en,
  input  wire logic [fr2p_pkg::IndexWidth-1:0]   wr_index,
  input  wire logic [fr2p_pkg::MaxWidth-1:0]     wr_data,
  output logic                                 done,
  output logic [fr2p_pkg::PixelWidth-1:0]        packed_pixel
);
  import fr2p_pkg::*;

  // pipelined lanes never stall
  assign busy = 1'b0;

  // configuration: mask analysis happens on the write itself
  logic      pixel_mode;
  chan_fmt_t fmt [ChanCount];

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_mode <= 1'b0;
      fmt[0] <= analyse_mask(RedMaskReset);
      fmt[1] <= analyse_mask(GreenMaskReset);
      fmt[2] <= analyse_mask(BlueMaskReset);
    end else if (wr_en) begin
      case (wr_index)
        RegPixelMode: pixel_mode <= wr_data[0];
        RegRedMask:   fmt[0] <= analyse_mask(wr_data);
        RegGreenMask: fmt[1] <= analyse_mask(wr_data);
        RegBlueMask:  fmt[2] <= analyse_mask(wr_data);
        default:      pixel_mode <= pixel_mode;
      endcase
    end
  end

  // three channel lanes side by side
  logic [ValueWidth-1:0] values [ChanCount];
  logic [MaxWidth-1:0]   chan   [ChanCount];
  logic [ChanCount-1:0]  lane_valid;
  logic                  accept;

  assign accept = start && !busy;
  assign values[0] = red_value;
  assign values[1] = green_value;
  assign values[2] = blue_value;

  for (genvar g = 0; g < ChanCount; g++) begin : g_lane
    fr2p_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (accept),
      .value     (values[g]),
      .maxv      (pixel_mode ? ByteMax : fmt[g].maxv),
      .out_valid (lane_valid[g]),
      .chan      (chan[g])
    );
  end

  // merge stage packs the word
  fr2p_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (lane_valid[0]),
    .pixel_mode   (pixel_mode),
    .chan         (chan),
    .fmt          (fmt),
    .done         (done),
    .packed_pixel (packed_pixel)
  );

  // lanes run in lock step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    lane_valid == '0 || lane_valid == '1)
    else $error("lanes out of step");

  // every accepted word yields a result once it has passed the lanes and the merge stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##3 done)
    else $error("result missing");

  // no result without a word accepted earlier that has passed the lanes and the merge stage
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 4))
    else $error("result without word");

endmodule
`default_nettype wire

// ===== verif/tb_float_rgb_to_packed_pixel_core.sv =====
// testbench for the float rgb to packed pixel core, self-checking against its own scaler model
`default_nettype none
module tb_float_rgb_to_packed_pixel_core;
  import fr2p_pkg::*;

  // expected packed pixels in order, with a count of mismatches
  class pixel_scoreboard;
    logic [PixelWidth-1:0] pending[$];
    int errors;
    int checked;

    function void note_word(logic [PixelWidth-1:0] px);
      pending.push_back(px);
    endfunction

    function void check_pixel(logic [PixelWidth-1:0] got);
      logic [PixelWidth-1:0] want;
      if (pending.size() == 0) begin
        $error("packed_pixel: no word expected, got %h", got);
        errors++;
      end else begin
        want = pending.pop_front();
        checked++;
        if (got !== want) begin
          $error("packed_pixel: expected %h, got %h", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [ValueWidth-1:0] red_value = '0, green_value = '0, blue_value = '0;
  logic wr_en = 1'b0;
  logic [IndexWidth-1:0] wr_index = RegPixelMode;
  logic [MaxWidth-1:0] wr_data = '0;
  logic done;
  logic [PixelWidth-1:0] packed_pixel;

  pixel_scoreboard board = new();

  // own copy of the block's settings
  logic byte_mode;
  logic [4:0] lane_shift[3];
  logic [15:0] lane_max[3];
  int idle_pct;
  int word_count;

  float_rgb_to_packed_pixel_core uut (
    .clk, .rst, .start, .busy, .red_value, .green_value, .blue_value,
    .wr_en, .wr_index, .wr_data, .done, .packed_pixel
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // generous ceiling on run length
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // lowest set bit and run of ones above it
  function automatic void mask_format(input logic [15:0] m, output logic [4:0] s,
                                      output logic [15:0] mx);
    int w;
    s = '0;
    mx = '0;
    w = 0;
    if (m != 0) begin
      while (m[s] == 1'b0) s++;
      while (s + w < 16 && m[s+w]) w++;
      mx = 16'((32'd1 << w) - 1);
    end
  endfunction

  // value times maximum, rounded to single precision, truncated, clamped
  function automatic logic [15:0] scale_lane(input logic [31:0] bits, input logic [15:0] mx);
    logic [7:0] ex;
    logic [22:0] fr;
    logic [63:0] mant, prod, r, rem, half;
    int e, d, len, sh;
    logic [63:0] v;
    ex = bits[30:23];
    fr = bits[22:0];
    if (ex == 8'hFF && fr != 0) return '0;
    if (bits[31]) return '0;
    if (ex >= 8'd127) return mx;
    if (ex == 0) begin
      mant = {41'd0, fr};
      e = -149;
    end else begin
      mant = {40'd0, 1'b1, fr};
      e = int'(ex) - 150;
    end
    prod = mant * {48'd0, mx};
    if (prod == 0) return '0;
    len = 0;
    while (len < 64 && (prod >> len) != 0) len++;
    d = (len > 24) ? len - 24 : 0;
    r = prod;
    if (d > 0) begin
      rem = prod & ((64'd1 << d) - 1);
      half = 64'd1 << (d - 1);
      r = prod >> d;
      if (rem > half || (rem == half && r[0])) r++;
    end
    sh = -(e + d);
    if (sh >= 64) return '0;
    v = r >> sh;
    return (v > {48'd0, mx}) ? mx : v[15:0];
  endfunction

  function automatic logic [PixelWidth-1:0] predict_pixel(input logic [31:0] rv, gv, bv);
    logic [31:0] px;
    logic [31:0] vals[3];
    logic [15:0] rc, gc, bc;
    vals[0] = rv;
    vals[1] = gv;
    vals[2] = bv;
    px = '0;
    if (byte_mode) begin
      rc = scale_lane(rv, ByteMax);
      gc = scale_lane(gv, ByteMax);
      bc = scale_lane(bv, ByteMax);
      px = {8'd0, rc[7:0], gc[7:0], bc[7:0]};
    end else begin
      for (int i = 0; i < 3; i++)
        px |= {16'd0, scale_lane(vals[i], lane_max[i])} << (lane_shift[i] & 5'd15);
      px &= 32'hFFFF;
    end
    return px[PixelWidth-1:0];
  endfunction

  // register write, only while idle
  task automatic write_reg(input logic [IndexWidth-1:0] idx, input logic [15:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      RegPixelMode: byte_mode = val[0];
      RegRedMask:   mask_format(val, lane_shift[0], lane_max[0]);
      RegGreenMask: mask_format(val, lane_shift[1], lane_max[1]);
      RegBlueMask:  mask_format(val, lane_shift[2], lane_max[2]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  // random gaps, then one word held until accepted; start stays high for back to back words
  task automatic send_word(input logic [31:0] rv, gv, bv);
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    red_value <= rv;
    green_value <= gv;
    blue_value <= bv;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_word(predict_pixel(rv, gv, bv));
    word_count++;
    @(negedge clk);
  endtask

  // wait for every pixel, then let the pipeline drain
  task automatic drain;
    int guard;
    guard = 0;
    start <= 1'b0;
    while (board.pending.size() != 0 && guard < 1000) begin
      @(negedge clk);
      guard++;
    end
    repeat (8) @(negedge clk);
  endtask

  // mostly nominal values in 0..1, plus edges and raw noise
  function automatic logic [31:0] rand_value;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 60) return {1'b0, 8'($urandom_range(126, 104)), 23'($urandom)};
    if (pick < 70) return {1'b0, 8'd126, 23'($urandom)};
    if (pick < 75) return 32'h3F80_0000;
    if (pick < 80) return {1'b0, 8'd0, 23'($urandom)};
    return $urandom;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) board.check_pixel(packed_pixel);
  end

  initial begin
    logic [31:0] edge_vals[14];
    logic [15:0] mask_sets[6][3];
    edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h7F80_0000,
                  32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001, 32'hBF00_0000,
                  32'h3F00_0000, 32'h3F7F_FFFF, 32'h0000_0001, 32'h007F_FFFF,
                  32'h4120_0000, 32'hFFFF_FFFF};
    // 5-6-5, zeros, full overlap, non-contiguous, 5-5-5 and top bits
    mask_sets = '{'{16'hF800, 16'h07E0, 16'h001F}, '{16'h0000, 16'h0000, 16'h0000},
                  '{16'hFFFF, 16'hFFFF, 16'hFFFF}, '{16'hA0F0, 16'h0505, 16'h8001},
                  '{16'h7C00, 16'h03E0, 16'h001F}, '{16'h8000, 16'h4000, 16'hFFFE}};
    byte_mode = 1'b0;
    mask_format(RedMaskReset, lane_shift[0], lane_max[0]);
    mask_format(GreenMaskReset, lane_shift[1], lane_max[1]);
    mask_format(BlueMaskReset, lane_shift[2], lane_max[2]);
    word_count = 0;
    idle_pct = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: edge values at reset masks, then in byte mode
    for (int i = 0; i < 14; i++) send_word(edge_vals[i], edge_vals[13-i], edge_vals[(i+5)%14]);
    drain();
    write_reg(RegPixelMode, 16'd1);
    for (int i = 0; i < 8; i++) send_word(edge_vals[i+6], edge_vals[i], edge_vals[i+3]);
    drain();

    // random phases across mask sets and modes, first with no gaps
    for (int ph = 0; ph < 14; ph++) begin
      int k;
      k = ph % 6;
      write_reg(RegPixelMode, (ph % 4 == 3) ? 16'd1 : 16'd0);
      write_reg(RegRedMask, (ph >= 6 && ph % 3 == 0) ? 16'($urandom) : mask_sets[k][0]);
      write_reg(RegGreenMask, mask_sets[k][1]);
      write_reg(RegBlueMask, mask_sets[k][2]);
      idle_pct = (ph == 0) ? 0 : 31;
      for (int n = 0; n < 122; n++) begin
        send_word(rand_value(), rand_value(), rand_value());
        // sender holds off until everything is back
        if (n == 60) begin
          start <= 1'b0;
          @(negedge clk);
          while (board.pending.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    $display("covered %0d words, %0d pixels checked, over 14 register settings and both modes",
             word_count, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
rtl/fr2p_pkg.sv
rtl/fr2p_lane.sv
rtl/fr2p_merge.sv
rtl/float_rgb_to_packed_pixel_core.sv
verif/tb_float_rgb_to_packed_pixel_core.sv
